### design/dvs_pkg.sv
`default_nettype none
package dvs_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegW      = 31;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned InDataW   = 168;
  localparam int unsigned OutDataW  = 136;
  localparam int unsigned QueueDepth = 2;

  localparam logic [RegIdxW-1:0] REG_MAX_LIN_VEL = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MAX_ANG_VEL = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_LIN_ACC = 3'd2;
  localparam logic [RegIdxW-1:0] REG_MAX_ANG_ACC = 3'd3;
  localparam logic [RegIdxW-1:0] REG_CMD_TIMEOUT = 3'd4;
  localparam logic [RegIdxW-1:0] REG_HALF_TRACK  = 3'd5;
  localparam logic [RegIdxW-1:0] REG_MOVING_THR  = 3'd6;
  localparam logic [RegIdxW-1:0] REG_ROTATE_THR  = 3'd7;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic [RegW-1:0] max_lin_vel;
    logic [RegW-1:0] max_ang_vel;
    logic [RegW-1:0] max_lin_acc;
    logic [RegW-1:0] max_ang_acc;
    logic [RegW-1:0] cmd_timeout;
    logic [RegW-1:0] half_track;
    logic [RegW-1:0] moving_thr;
    logic [RegW-1:0] rotate_thr;
  } cfg_t;

  typedef struct packed {
    logic               is_tick;
    logic signed [31:0] desired_linear;
    logic signed [31:0] desired_angular;
    logic [15:0]        elapsed;
    logic [16:0]        safety_scale;
    logic signed [31:0] measured_linear;
    logic signed [31:0] measured_angular;
  } item_t;

  typedef struct packed {
    logic signed [31:0] left_wheel_speed;
    logic signed [31:0] right_wheel_speed;
    logic signed [31:0] sent_linear;
    logic signed [31:0] sent_angular;
    logic               drive_enable;
    logic               timed_out;
  } res_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;

  // Move cur toward target by at most step.
  function automatic logic signed [31:0] slew(input logic signed [31:0] cur,
                                              input logic signed [31:0] target,
                                              input logic [31:0] step);
    logic signed [33:0] c;
    logic signed [33:0] t;
    logic signed [33:0] s;
    c = 34'(cur);
    t = 34'(target);
    if (t > c) begin
      s = c + $signed({2'b00, step});
      if (s > t) s = t;
    end else begin
      s = c - $signed({2'b00, step});
      if (s < t) s = t;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -49'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

### design/diff_drive_velocity_shaper.sv
`default_nettype none
// Channel | Dir | tdata (low bit up)                                   | tuser
// in_     | in  | desired_linear, desired_angular, elapsed,            | operation
//         |     | safety_scale, measured_linear, measured_angular, pad |
// out_    | out | left_wheel_speed, right_wheel_speed, sent_linear,    | -
//         |     | sent_angular, drive_enable, timed_out, pad           |
// cfg_    | in  | we, index (3b), wdata (31b)                          | -
//
// A command transfer is consumed when the back end pops it from the queue
// in its idle state. A tick result passes the limit, clamp, ramp, offset
// and output states, plus a multiply and the 32-step restoring divider when
// the angular ratio needs a divide; the 33x33 multiplier is shared by them.
// rst_n is synchronous, active low; it clears the queue, the shaping state
// and the output valid, and loads the register reset values.
// A stalled output holds the back end in its final step; the two-entry
// queue keeps accepting input until it fills.
module diff_drive_velocity_shaper
  import dvs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,   // dl, da, elapsed, scale, ml, ma
  input  wire logic                in_tuser,   // operation
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,  // left, right, sl, sa, en, tout
  input  wire logic                cfg_we,
  input  wire logic [RegIdxW-1:0]  cfg_index,
  input  wire logic [RegW-1:0]     cfg_wdata
);

  logic [RegW-1:0] regs_r [NumRegs];
  cfg_t            cfg;
  item_t           in_item, q_item;
  qctl_t           q_st;
  logic            q_pop;
  res_t            res;

  // Register file; hold values between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_MAX_LIN_VEL] <= 31'd65536;
      regs_r[REG_MAX_ANG_VEL] <= 31'd294912;
      regs_r[REG_MAX_LIN_ACC] <= 31'd49152;
      regs_r[REG_MAX_ANG_ACC] <= 31'd196608;
      regs_r[REG_CMD_TIMEOUT] <= 31'd16384;
      regs_r[REG_HALF_TRACK]  <= 31'd12280;
      regs_r[REG_MOVING_THR]  <= 31'd3277;
      regs_r[REG_ROTATE_THR]  <= 31'd3277;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  assign cfg.max_lin_vel = regs_r[REG_MAX_LIN_VEL];
  assign cfg.max_ang_vel = regs_r[REG_MAX_ANG_VEL];
  assign cfg.max_lin_acc = regs_r[REG_MAX_LIN_ACC];
  assign cfg.max_ang_acc = regs_r[REG_MAX_ANG_ACC];
  assign cfg.cmd_timeout = regs_r[REG_CMD_TIMEOUT];
  assign cfg.half_track  = regs_r[REG_HALF_TRACK];
  assign cfg.moving_thr  = regs_r[REG_MOVING_THR];
  assign cfg.rotate_thr  = regs_r[REG_ROTATE_THR];

  // Unpack the input transfer
  assign in_item.is_tick          = in_tuser;
  assign in_item.desired_linear   = in_tdata[31:0];
  assign in_item.desired_angular  = in_tdata[63:32];
  assign in_item.elapsed          = in_tdata[79:64];
  assign in_item.safety_scale     = in_tdata[96:80];
  assign in_item.measured_linear  = in_tdata[128:97];
  assign in_item.measured_angular = in_tdata[160:129];

  dvs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_st     (q_st),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  dvs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_st      (q_st),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result transfer; pad the top bits with zeros
  assign out_tdata = {6'd0, res.timed_out, res.drive_enable, res.sent_angular,
                      res.sent_linear, res.right_wheel_speed, res.left_wheel_speed};

  // Drive disabled means both sent velocities are zero, so the wheels are too
  a_idle_wheels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.drive_enable |-> res.left_wheel_speed == 0 &&
      res.right_wheel_speed == 0)
    else $error("wheel speed nonzero with drive disabled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Nothing leaves the queue unless something is in it
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_st.valid)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

### design/dvs_front.sv
`default_nettype none
module dvs_front
  import dvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire item_t in_item,
  output qctl_t     q_st,
  input  wire logic q_pop,
  output item_t     q_item
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t            mem_r [QueueDepth];
  logic [PtrW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PtrW:0]    cnt_r, cnt_nxt;
  logic             push;

  assign in_ready = (cnt_r != (PtrW+1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_item   = mem_r[rd_r];
  assign q_st.valid = (cnt_r != '0);
  assign q_st.pop   = q_pop;

  always_comb begin
    wr_nxt  = push  ? PtrW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = q_pop ? PtrW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= in_item;
  end

endmodule
`default_nettype wire

### design/dvs_back.sv
`default_nettype none
module dvs_back
  import dvs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire qctl_t q_st,
  output logic       q_pop,
  input  wire item_t q_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LIM   = 12'b000000000010,
    S_X     = 12'b000000000100,
    S_MUL   = 12'b000000001000,
    S_DINIT = 12'b000000010000,
    S_DIV   = 12'b000000100000,
    S_RCL   = 12'b000001000000,
    S_STEPL = 12'b000010000000,
    S_RAMPL = 12'b000100000000,
    S_RAMPA = 12'b001000000000,
    S_OFF   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } st_t;

  st_t st_r, st_nxt;

  logic signed [31:0] held_lin_r, held_ang_r, ramp_lin_r, ramp_ang_r;
  logic [31:0]        since_r;
  logic [15:0]        elapsed_r;
  logic [16:0]        scale_r;
  logic               tout_r, en_meas_r, bypass_r, neg_r;
  logic signed [31:0] x_r, r_r;
  logic signed [65:0] p_r;
  logic [31:0]        rem_r, quo_r, dvs_r;
  logic [4:0]         cnt_r;
  logic               out_valid_r;
  res_t               out_r;

  // Shared multiplier operands
  logic signed [32:0] ma, mb;
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_LIM:   begin ma = {2'b00, cfg.max_lin_vel}; mb = {16'd0, scale_r}; end
      S_MUL:   begin ma = 33'(held_ang_r); mb = 33'(x_r); end
      S_STEPL: begin ma = {2'b00, cfg.max_lin_acc}; mb = {17'd0, elapsed_r}; end
      S_RAMPL: begin ma = {2'b00, cfg.max_ang_acc}; mb = {17'd0, elapsed_r}; end
      S_OFF:   begin ma = 33'(ramp_ang_r); mb = {2'b00, cfg.half_track}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Pop side
  logic [32:0] since_sum;
  logic [31:0] since_sat;
  logic        tout_now;
  logic [32:0] abs_ml, abs_ma;
  always_comb begin
    since_sum = {1'b0, since_r} + {17'd0, q_item.elapsed};
    since_sat = since_sum[32] ? 32'hFFFFFFFF : since_sum[31:0];
    tout_now  = since_sat >= {1'b0, cfg.cmd_timeout};
    abs_ml = q_item.measured_linear[31] ? 33'(-34'(q_item.measured_linear))
                                        : 33'(q_item.measured_linear);
    abs_ma = q_item.measured_angular[31] ? 33'(-34'(q_item.measured_angular))
                                         : 33'(q_item.measured_angular);
  end

  // Limit and clamp
  logic signed [32:0] lim, hl;
  logic signed [32:0] x_c;
  always_comb begin
    lim = p_r[47] ? 33'sh07FFFFFFF : {1'b0, p_r[47:16]};
    hl  = 33'(held_lin_r);
    if (hl > lim)       x_c = lim;
    else if (hl < -lim) x_c = -lim;
    else                x_c = hl;
  end

  // Divider
  logic [63:0] num_mag;
  logic [32:0] shifted;
  logic        qbit;
  always_comb begin
    num_mag = p_r[65] ? 64'(-p_r) : p_r[63:0];
    shifted = {rem_r, quo_r[31]};
    qbit    = shifted >= {1'b0, dvs_r};
  end

  // Angular clamp
  logic signed [32:0] rq, rmax, r_c;
  always_comb begin
    rq   = bypass_r ? 33'(held_ang_r)
                    : (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}));
    rmax = {2'b00, cfg.max_ang_vel};
    if (rq > rmax)       r_c = rmax;
    else if (rq < -rmax) r_c = -rmax;
    else                 r_c = rq;
  end

  // Wheel speeds
  logic signed [48:0] offset, left_w, right_w;
  always_comb begin
    offset  = p_r[64:16];
    left_w  = 49'(ramp_lin_r) - offset;
    right_w = 49'(ramp_lin_r) + offset;
  end

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (st_r == S_IDLE) && q_st.valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_st.valid && q_item.is_tick == OP_TICK) st_nxt = S_LIM;
      S_LIM:   st_nxt = S_X;
      S_X:     st_nxt = (held_lin_r == 0 || x_c == hl) ? S_RCL : S_MUL;
      S_MUL:   st_nxt = S_DINIT;
      S_DINIT: st_nxt = S_DIV;
      S_DIV:   if (cnt_r == 5'd31) st_nxt = S_RCL;
      S_RCL:   st_nxt = S_STEPL;
      S_STEPL: st_nxt = S_RAMPL;
      S_RAMPL: st_nxt = S_RAMPA;
      S_RAMPA: st_nxt = S_OFF;
      S_OFF:   st_nxt = S_OUT;
      S_OUT:   if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      held_lin_r  <= '0;
      held_ang_r  <= '0;
      ramp_lin_r  <= '0;
      ramp_ang_r  <= '0;
      since_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // Raise valid when a new result lands, drop it once the old one is taken
      if (st_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)            out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_st.valid) begin
            if (q_item.is_tick == OP_COMMAND) begin
              held_lin_r <= q_item.desired_linear;
              held_ang_r <= q_item.desired_angular;
              since_r    <= '0;
            end else begin
              since_r <= since_sat;
              if (tout_now) begin
                held_lin_r <= '0;
                held_ang_r <= '0;
              end
            end
          end
        end
        S_RAMPL: ramp_lin_r <= slew(ramp_lin_r, x_r, p_r[47:16]);
        S_RAMPA: ramp_ang_r <= slew(ramp_ang_r, r_r, p_r[47:16]);
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Hold the wheel offset product while the result waits
    if (st_r != S_OUT) p_r <= ma * mb;
    case (st_r)
      S_IDLE: begin
        elapsed_r <= q_item.elapsed;
        scale_r   <= q_item.safety_scale;
        tout_r    <= tout_now;
        en_meas_r <= (abs_ml > {2'b00, cfg.moving_thr}) ||
                     (abs_ma > {2'b00, cfg.rotate_thr});
      end
      S_X: begin
        x_r      <= x_c[31:0];
        bypass_r <= (held_lin_r == 0) || (x_c == hl);
        neg_r    <= held_ang_r[31] ^ x_c[32] ^ held_lin_r[31];
        dvs_r    <= held_lin_r[31] ? 32'(-33'(held_lin_r)) : held_lin_r;
      end
      S_DINIT: begin
        rem_r <= num_mag[63:32];
        quo_r <= num_mag[31:0];
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= qbit ? 32'(shifted - {1'b0, dvs_r}) : shifted[31:0];
        quo_r <= {quo_r[30:0], qbit};
        cnt_r <= cnt_r + 5'd1;
      end
      S_RCL: r_r <= r_c[31:0];
      S_OUT: begin
        if (out_free) begin
          out_r.left_wheel_speed  <= sat32(left_w);
          out_r.right_wheel_speed <= sat32(right_w);
          out_r.sent_linear       <= ramp_lin_r;
          out_r.sent_angular      <= ramp_ang_r;
          out_r.drive_enable      <= en_meas_r || (ramp_lin_r != 0) || (ramp_ang_r != 0);
          out_r.timed_out         <= tout_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
